FILE: rtl/core/ped_pkg.sv
// Shared types and codes for the prefix edit distance check.
// Used by the controller, the datapath, the cell and the top level.
package ped_pkg;

    localparam int CHAR_W  = 16;
    localparam int DELTA_W = 6;
    localparam int OP_W    = 2;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [DELTA_W-1:0] t_delta;
    typedef logic [OP_W-1:0]    t_op;

    // Request operation codes
    localparam t_op OP_LOAD_Q = 2'd0;
    localparam t_op OP_LOAD_C = 2'd1;
    localparam t_op OP_CHECK  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_q;
        logic load_c;
        logic init;
        logic sweep;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic src_done;
        logic pipe_empty;
    } t_sts;

    // Column marker and candidate character passed from cell to cell
    typedef struct packed {
        logic  vld;
        t_char ch;
    } t_tap;

endpackage

FILE: rtl/core/prefix_edit_distance_check.sv
// Top level of the prefix edit distance check.
// Depends on ped_pkg; instantiates ped_ctrl and ped_dp.
//
//   channel   handshake          payload
//   request   start / busy       i_op, i_ch, i_max_edits
//   result    o_valid (1 cycle)  o_match, o_overflow
//
// A load request (op 0 or 1) leaves busy low.
// A check holds busy until all ncol columns have been issued and have left the query cells, where
// ncol is the smaller of qlen + max_edits and the candidate length: characters
// leave the candidate memory one a cycle and cross the query cells one a cycle.
// The result strobe is high in the first cycle with busy low; the receiver cannot stall.
// Reset is synchronous and clears lengths, overflow flag and control state.
module prefix_edit_distance_check #(
    parameter int MAX_QUERY = 32,
    parameter int MAX_CAND  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ped_pkg::t_op    i_op,
    input  ped_pkg::t_char  i_ch,
    input  ped_pkg::t_delta i_max_edits,
    output logic            o_valid,
    output logic            o_match,
    output logic            o_overflow
);
    import ped_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence requests
    ped_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Buffers and cell array
    ped_dp #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_CAND  (MAX_CAND)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_ch        (i_ch),
        .i_max_edits (i_max_edits),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_match     (o_match),
        .o_overflow  (o_overflow)
    );

endmodule

FILE: rtl/core/ped_cell.sv
// One query row cell of the systolic edit distance array.
// Depends on ped_pkg for the tap type and character width.
module ped_cell #(
    parameter int W = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_init,
    input  logic [W-1:0]  i_init_val,
    input  ped_pkg::t_char i_qch,
    input  ped_pkg::t_tap i_up,
    input  logic [W-1:0]  i_up_val,
    output ped_pkg::t_tap o_tap,
    output logic [W-1:0]  o_val
);
    import ped_pkg::*;

    logic         r_vld;
    t_char        r_ch;
    logic [W-1:0] r_val;
    logic [W-1:0] r_diag;
    logic [W:0]   w_sub;
    logic [W:0]   w_ins;
    logic [W:0]   w_del;
    logic [W:0]   w_min;

    // Cheapest of substitution, insertion and deletion
    always_comb begin
        w_sub = {1'b0, r_diag} + {{W{1'b0}}, (i_qch != i_up.ch)};
        w_ins = {1'b0, r_val} + {{W{1'b0}}, 1'b1};
        w_del = {1'b0, i_up_val} + {{W{1'b0}}, 1'b1};
        w_min = w_sub;
        if (w_ins < w_min) begin
            w_min = w_ins;
        end
        if (w_del < w_min) begin
            w_min = w_del;
        end
    end

    // Column marker is registered and follows the upstream cell in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_init) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_up.vld;
        end
    end

    // Load column zero on init, else advance one column per marker
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_val  <= i_init_val;
            r_diag <= i_init_val - W'(1);
        end else if (i_up.vld) begin
            r_val  <= w_min[W-1:0];
            r_diag <= i_up_val;
            r_ch   <= i_up.ch;
        end
    end

    assign o_tap.vld = r_vld;
    assign o_tap.ch  = r_ch;
    assign o_val     = r_val;

endmodule

FILE: rtl/core/ped_ctrl.sv
// Controller state machine for the prefix edit distance check.
// Depends on ped_pkg for operation codes and command/status structs.
module ped_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ped_pkg::t_op  i_op,
    input  ped_pkg::t_sts i_sts,
    output ped_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import ped_pkg::*;

    localparam logic [0:0] S_IDLE  = 1'b0;
    localparam logic [0:0] S_SWEEP = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;
    logic       w_accept;

    // Decode the request into datapath commands
    always_comb begin
        w_accept     = i_start && (r_state == S_IDLE);
        o_cmd.load_q = w_accept && (i_op == OP_LOAD_Q);
        o_cmd.load_c = w_accept && (i_op == OP_LOAD_C);
        o_cmd.init   = w_accept && (i_op == OP_CHECK);
        o_cmd.sweep  = (r_state == S_SWEEP);
        o_cmd.finish = o_cmd.sweep && i_sts.src_done && i_sts.pipe_empty;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.init) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (o_cmd.finish) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/ped_dp.sv
// Datapath: query and candidate buffers, column source and the cell array.
// Depends on ped_pkg and instantiates ped_cell once per query buffer slot (MAX_QUERY cells).
module ped_dp #(
    parameter int MAX_QUERY = 32,
    parameter int MAX_CAND  = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ped_pkg::t_cmd   i_cmd,
    input  ped_pkg::t_char  i_ch,
    input  ped_pkg::t_delta i_max_edits,
    output ped_pkg::t_sts   o_sts,
    output logic            o_valid,
    output logic            o_match,
    output logic            o_overflow
);
    import ped_pkg::*;

    localparam int QLW  = $clog2(MAX_QUERY + 1);
    localparam int CLW  = $clog2(MAX_CAND + 1);
    localparam int QAW  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int CAW  = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
    localparam int VMAX = (MAX_QUERY > MAX_CAND) ? MAX_QUERY : MAX_CAND;
    localparam int VW   = $clog2(VMAX + 1);
    localparam int SW   = ((QLW > DELTA_W) ? QLW : DELTA_W) + 1;
    localparam int NW   = (SW > VW) ? SW : VW;

    t_char           r_qch [MAX_QUERY];
    t_char           r_cmem [MAX_CAND];
    logic [QLW-1:0]  r_qlen;
    logic [CLW-1:0]  r_clen;
    logic            r_drop;
    t_delta          r_delta;
    logic [CLW-1:0]  r_ncol;
    logic [CLW-1:0]  r_col;
    logic            r_rd_vld;
    logic [VW-1:0]   r_rd_col;
    t_char           r_rd_ch;
    logic            r_hit;
    logic            r_valid;
    logic            r_match;
    logic            r_ovf;

    t_tap            w_tap [MAX_QUERY+1];
    logic [VW-1:0]   w_val [MAX_QUERY+1];
    logic [NW-1:0]   w_span;
    logic [NW-1:0]   w_clen;
    logic            w_issue;
    logic            w_active;
    logic            w_last_hit;

    // Candidate window: query length plus allowance, capped by candidate length
    assign w_span  = NW'(r_qlen) + NW'(i_max_edits);
    assign w_clen  = NW'(r_clen);
    assign w_issue = i_cmd.sweep && (r_col != r_ncol);

    // Query buffer, lengths and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            r_clen <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.finish) begin
            r_qlen <= '0;
            r_clen <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.load_q) begin
            if (r_qlen != QLW'(MAX_QUERY)) begin
                r_qlen <= r_qlen + QLW'(1);
            end else begin
                r_drop <= 1'b1;
            end
        end else if (i_cmd.load_c) begin
            if (r_clen != CLW'(MAX_CAND)) begin
                r_clen <= r_clen + CLW'(1);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q && (r_qlen != QLW'(MAX_QUERY))) begin
            r_qch[r_qlen[QAW-1:0]] <= i_ch;
        end
    end

    // Candidate memory: written on load, read one column per cycle in the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_c && (r_clen != CLW'(MAX_CAND))) begin
            r_cmem[r_clen[CAW-1:0]] <= i_ch;
        end
        if (w_issue) begin
            r_rd_ch <= r_cmem[r_col[CAW-1:0]];
        end
    end

    // Column source: set up the window on init, then issue columns in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_col    <= '0;
        end else if (i_cmd.init) begin
            r_rd_vld <= 1'b0;
            r_col    <= '0;
        end else begin
            r_rd_vld <= w_issue;
            if (w_issue) begin
                r_col <= r_col + CLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_delta <= i_max_edits;
            r_ncol  <= (w_span < w_clen) ? w_span[CLW-1:0] : r_clen;
        end
        if (w_issue) begin
            r_rd_col <= VW'(r_col) + VW'(1);
        end
    end

    // Row zero of the table comes straight from the column source
    assign w_tap[0].vld = r_rd_vld;
    assign w_tap[0].ch  = r_rd_ch;
    assign w_val[0]     = r_rd_col;

    // One cell per query buffer slot
    for (genvar k = 1; k <= MAX_QUERY; k++) begin : g_cell
        ped_cell #(
            .W (VW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (i_cmd.init),
            .i_init_val (VW'(k)),
            .i_qch      (r_qch[k-1]),
            .i_up       (w_tap[k-1]),
            .i_up_val   (w_val[k-1]),
            .o_tap      (w_tap[k]),
            .o_val      (w_val[k])
        );
    end

    // Pipeline activity up to the last query row
    always_comb begin
        w_active = 1'b0;
        for (int k = 0; k <= MAX_QUERY; k++) begin
            if (w_tap[k].vld && (QLW'(k) <= r_qlen)) begin
                w_active = 1'b1;
            end
        end
    end

    assign w_last_hit = w_tap[r_qlen].vld &&
                        (NW'(w_val[r_qlen]) <= NW'(r_delta));

    // Track whether any entry of the last row is within the allowance
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_hit <= (NW'(r_qlen) <= NW'(i_max_edits));
        end else if (w_last_hit) begin
            r_hit <= 1'b1;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_match <= r_hit;
            r_ovf   <= r_drop;
        end
    end

    assign o_sts.src_done   = (r_col == r_ncol);
    assign o_sts.pipe_empty = !w_active;
    assign o_valid          = r_valid;
    assign o_match          = r_match;
    assign o_overflow       = r_ovf;

endmodule
